@@ src/bpat_pkg.sv @@
// Breakpoint address table: shared types, codes and defaults.
// No dependencies; used by every module of the block.
package bpat_pkg;

    // Field widths fixed by the transfer format
    localparam int unsigned ADDR_W  = 16;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned CNT_W   = 5;

    // Default number of entries
    localparam int unsigned DEPTH_DEFAULT = 16;

    // Operation codes
    localparam logic [FUNC_W-1:0] OP_CHECK  = 2'd0;
    localparam logic [FUNC_W-1:0] OP_SET    = 2'd1;
    localparam logic [FUNC_W-1:0] OP_DELETE = 2'd2;
    localparam logic [FUNC_W-1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_ALREADY = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic ins_en;   // open a slot and insert the address
        logic del_en;   // close the slot of the matching entry
    } cell_ctrl_t;

endpackage

@@ src/breakpoint_address_table_unit.sv @@
// Breakpoint address table. A sorted chain of DEPTH cells, one address each,
// checked in parallel against every incoming address. One transfer is taken
// per clock and its result appears on the m_ side in the cycle after; a set or
// delete moves every entry at or above the lower bound one cell along the
// chain in that same cycle. The input stalls only while an unaccepted result
// sits in the output register.
module breakpoint_address_table_unit #(
    parameter int unsigned DEPTH = bpat_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [1:0] func, [17:2] address, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] hit, [2:1] status, [7:3] entry_count
);

    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [bpat_pkg::FUNC_W-1:0] func;
    logic [bpat_pkg::ADDR_W-1:0] addr;
    logic                        accept;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    logic [DEPTH-1:0]            valid;
    logic [DEPTH-1:0]            lt;
    logic [DEPTH-1:0]            eq;
    logic [bpat_pkg::ADDR_W-1:0] entry [DEPTH];

    logic                  found;
    logic                  full;
    bpat_pkg::cell_ctrl_t  ctrl;

    logic                        hit;
    logic [bpat_pkg::STAT_W-1:0] status;
    logic [CW+4:0]               count_ext;

    logic       m_tvalid_reg;
    logic       m_tvalid_next;
    logic [7:0] m_tdata_reg;

    assign func   = s_tdata[1:0];
    assign addr   = s_tdata[17:2];
    assign accept = s_tvalid && s_tready;

    assign s_tready = !m_tvalid_reg || m_tready;

    // Cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                        lt_left;
        logic [bpat_pkg::ADDR_W-1:0] entry_left;
        logic [bpat_pkg::ADDR_W-1:0] entry_right;

        assign valid[i] = count_reg > CW'(i);

        if (i == 0) begin : g_first
            assign lt_left    = 1'b1;
            assign entry_left = addr;
        end else begin : g_mid
            assign lt_left    = lt[i-1];
            assign entry_left = entry[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign entry_right = entry[i];
        end else begin : g_body
            assign entry_right = entry[i+1];
        end

        bpat_cell u_cell (
            .aclk          (aclk),
            .valid_i       (valid[i]),
            .addr_i        (addr),
            .ctrl_i        (ctrl),
            .lt_left_i     (lt_left),
            .entry_left_i  (entry_left),
            .entry_right_i (entry_right),
            .lt_o          (lt[i]),
            .eq_o          (eq[i]),
            .entry_o       (entry[i])
        );
    end

    assign found = |eq;
    assign full  = count_reg == CW'(DEPTH);

    // Decode the operation into shift commands, status and next count
    always_comb begin
        ctrl       = '0;
        hit        = found;
        status     = bpat_pkg::ST_OK;
        count_next = count_reg;
        unique case (func)
            bpat_pkg::OP_CHECK: begin
            end
            bpat_pkg::OP_SET: begin
                priority if (found) begin
                    status = bpat_pkg::ST_ALREADY;
                end else if (full) begin
                    status = bpat_pkg::ST_FULL;
                end else begin
                    ctrl.ins_en = accept;
                    count_next  = count_reg + CW'(1);
                end
            end
            bpat_pkg::OP_DELETE: begin
                if (!found) begin
                    status = bpat_pkg::ST_ABSENT;
                end else begin
                    ctrl.del_en = accept;
                    count_next  = count_reg - CW'(1);
                end
            end
            default: begin
                hit        = 1'b0;
                count_next = '0;
            end
        endcase
    end

    assign count_ext = {5'b0, count_next};

    // Count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (accept) begin
            count_reg <= count_next;
        end
    end

    // Output register
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {count_ext[4:0], status, hit};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ src/bpat_cell.sv @@
// One cell of the sorted address chain: holds one entry, compares it with
// the search address and shifts to or from its neighbors. Uses bpat_pkg.
module bpat_cell (
    input  logic                       aclk,
    input  logic                       valid_i,        // cell index below count
    input  logic [bpat_pkg::ADDR_W-1:0] addr_i,
    input  bpat_pkg::cell_ctrl_t       ctrl_i,
    input  logic                       lt_left_i,      // left neighbor holds an entry below the search address
    input  logic [bpat_pkg::ADDR_W-1:0] entry_left_i,
    input  logic [bpat_pkg::ADDR_W-1:0] entry_right_i,
    output logic                       lt_o,
    output logic                       eq_o,
    output logic [bpat_pkg::ADDR_W-1:0] entry_o
);

    logic [bpat_pkg::ADDR_W-1:0] entry_reg;
    logic [bpat_pkg::ADDR_W-1:0] entry_next;

    // Compare against the search address
    always_comb begin
        lt_o = valid_i && (entry_reg < addr_i);
        eq_o = valid_i && (entry_reg == addr_i);
    end

    // Cells at or above the lower bound move: right on insert, left on delete
    always_comb begin
        priority if (ctrl_i.ins_en && !lt_o) begin
            entry_next = lt_left_i ? addr_i : entry_left_i;
        end else if (ctrl_i.del_en && !lt_o) begin
            entry_next = entry_right_i;
        end else begin
            entry_next = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_o = entry_reg;

endmodule

@@ src/bpat_checker.sv @@
// Port-level checks for the breakpoint address table, bound to the top level.
// Uses bpat_pkg for status codes.
module bpat_checker #(
    parameter int unsigned DEPTH = bpat_pkg::DEPTH_DEFAULT
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    localparam logic [4:0] FULL5 = 5'(DEPTH);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Already set implies a hit, not set implies a miss
    a_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] == bpat_pkg::ST_ALREADY) |-> m_tdata[0])
        else $error("already-set status without hit");

    a_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] == bpat_pkg::ST_ABSENT) |-> !m_tdata[0])
        else $error("not-set status with hit");

    // Full is reported only with a full table
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] == bpat_pkg::ST_FULL) |-> m_tdata[7:3] == FULL5)
        else $error("table-full status with room left");

endmodule

bind breakpoint_address_table_unit bpat_checker #(.DEPTH(DEPTH)) u_bpat_checker (.*);
